@@ rtl/kwsc_pkg.sv @@
`timescale 1ns / 1ps

package kwsc_pkg;

  // Default window length in bases
  localparam int KmerSize = 31;

  // Field widths fixed by the interface
  localparam int BaseW  = 8;
  localparam int QualW  = 7;
  localparam int SkipW  = 5;
  localparam int RunW   = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  // Saturation point of the stored run length
  localparam logic [RunW-1:0] RunMax = {RunW{1'b1}};

  // Nucleotide characters, both cases
  localparam logic [BaseW-1:0] ChLowA = 8'h61;
  localparam logic [BaseW-1:0] ChUpA  = 8'h41;
  localparam logic [BaseW-1:0] ChLowC = 8'h63;
  localparam logic [BaseW-1:0] ChUpC  = 8'h43;
  localparam logic [BaseW-1:0] ChLowG = 8'h67;
  localparam logic [BaseW-1:0] ChUpG  = 8'h47;
  localparam logic [BaseW-1:0] ChLowT = 8'h74;
  localparam logic [BaseW-1:0] ChUpT  = 8'h54;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFastqMode    = 2'd0,
    CfgQualityLimit = 2'd1,
    CfgRunLimit     = 2'd2
  } cfg_idx_e;

  // True for A, C, G or T in either case
  function automatic logic is_acgt(input logic [BaseW-1:0] c);
    return (c == ChLowA) || (c == ChUpA) || (c == ChLowC) || (c == ChUpC) ||
           (c == ChLowG) || (c == ChUpG) || (c == ChLowT) || (c == ChUpT);
  endfunction

endpackage

@@ rtl/kmer_window_skip_check.sv @@
`timescale 1ns / 1ps

// Sliding k-mer window checker. Each accepted beat shifts one base and its
// quality byte into a WINDOW_LEN-deep shift line and produces one result beat.
// A new beat is taken every cycle unless stalled. The result sits in an output
// register, and a stalled result holds off the input in the same cycle. The
// window is cleared by read_start_i on the first base of a read. Once it holds
// WINDOW_LEN bases of the current read, skip_count_o gives how many leading bases
// to drop so that no non-ACGT base, no low-quality base (FASTQ mode, nonzero
// limit) and no homopolymer run reaching run_limit falls inside the k-mer;
// run_base_o gives the base of such a run that ends the window. Each entry
// carries its run length, computed as it enters, so all positions are checked
// in parallel and a priority encoder picks the last hit in the same cycle.
// Configuration is written through a plain write port; the user must do so only
// while the block is idle, which the block itself does not enforce.
module kmer_window_skip_check #(
  parameter int WINDOW_LEN = kwsc_pkg::KmerSize
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [kwsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kwsc_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kwsc_pkg::BaseW-1:0]    base_char_i,
  input  logic [kwsc_pkg::QualW-1:0]    quality_char_i,
  input  logic                          read_start_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          window_full_o,
  output logic [kwsc_pkg::SkipW-1:0]    skip_count_o,
  output logic [kwsc_pkg::BaseW-1:0]    run_base_o
);

  localparam int FillW = $clog2(WINDOW_LEN + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW_LEN);

  // configuration registers
  logic                          fastq_mode_q;
  logic [kwsc_pkg::QualW-1:0]    quality_limit_q;
  logic [kwsc_pkg::RunW-1:0]     run_limit_q;

  // window shift line, oldest entry at index 0
  logic [kwsc_pkg::BaseW-1:0] base_q [WINDOW_LEN];
  logic [kwsc_pkg::BaseW-1:0] base_d [WINDOW_LEN];
  logic [kwsc_pkg::QualW-1:0] qual_q [WINDOW_LEN];
  logic [kwsc_pkg::QualW-1:0] qual_d [WINDOW_LEN];
  logic [kwsc_pkg::RunW-1:0]  run_q  [WINDOW_LEN];
  logic [kwsc_pkg::RunW-1:0]  run_d  [WINDOW_LEN];

  logic [FillW-1:0] fill_q, fill_d, fill_base;

  // result register
  logic                       out_valid_q;
  logic                       full_q, full_d;
  logic [kwsc_pkg::SkipW-1:0] skip_q, skip_d;
  logic [kwsc_pkg::BaseW-1:0] runb_q, runb_d;

  logic in_acc;
  logic [WINDOW_LEN-1:0] hit;
  logic qual_en, run_en;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign qual_en    = fastq_mode_q && (quality_limit_q != '0);
  assign run_en     = (run_limit_q != '0);

  // fill count: clear on a new read, saturate at the window length
  always_comb begin
    fill_base = read_start_i ? '0 : fill_q;
    fill_d    = (fill_base < FillFull) ? fill_base + 1'b1 : fill_base;
    full_d    = (fill_d == FillFull);
  end

  // shift the new base in and extend the run of the newest entry
  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      base_d[i] = base_q[i+1];
      qual_d[i] = qual_q[i+1];
      run_d[i]  = run_q[i+1];
    end
    base_d[WINDOW_LEN-1] = base_char_i;
    qual_d[WINDOW_LEN-1] = quality_char_i;
    if ((fill_base != '0) && (base_char_i == base_q[WINDOW_LEN-1])) begin
      run_d[WINDOW_LEN-1] = (run_q[WINDOW_LEN-1] == kwsc_pkg::RunMax) ?
                            kwsc_pkg::RunMax : run_q[WINDOW_LEN-1] + 1'b1;
    end else begin
      run_d[WINDOW_LEN-1] = kwsc_pkg::RunW'(1);
    end
  end

  // flag every position in parallel, then take the last hit
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      hit[i] = !kwsc_pkg::is_acgt(base_d[i]) ||
               (qual_en && (qual_d[i] <= quality_limit_q)) ||
               ((i >= 1) && run_en && (run_d[i] >= run_limit_q) &&
                ((i + 1) >= int'(run_limit_q)));
    end
    skip_d = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (hit[i]) begin
        skip_d = kwsc_pkg::SkipW'(i + 1);
      end
    end
    if (run_en && (run_d[WINDOW_LEN-1] >= run_limit_q) &&
        (WINDOW_LEN >= int'(run_limit_q))) begin
      runb_d = base_d[WINDOW_LEN-1];
    end else begin
      runb_d = '0;
    end
    if (!full_d) begin
      skip_d = '0;
      runb_d = '0;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fastq_mode_q    <= 1'b0;
      quality_limit_q <= '0;
      run_limit_q     <= '0;
    end else if (cfg_we_i) begin
      case (kwsc_pkg::cfg_idx_e'(cfg_idx_i))
        kwsc_pkg::CfgFastqMode:    fastq_mode_q    <= cfg_data_i[0];
        kwsc_pkg::CfgQualityLimit: quality_limit_q <= cfg_data_i;
        kwsc_pkg::CfgRunLimit:     run_limit_q     <= cfg_data_i[kwsc_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  // control: fill count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: advance the window and load the result on each input beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        base_q[i] <= base_d[i];
        qual_q[i] <= qual_d[i];
        run_q[i]  <= run_d[i];
      end
      full_q <= full_d;
      skip_q <= skip_d;
      runb_q <= runb_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_full_o = full_q;
  assign skip_count_o  = skip_q;
  assign run_base_o    = runb_q;

endmodule
